[hw/rtl/htbd_pkg.sv]
// Shared types, constants and control store of the Huffman tree bit decoder.
package htbd_pkg;

  localparam int unsigned MaxNodesDef   = 512;
  localparam int unsigned SymbolBitsDef = 16;

  localparam int unsigned IdxW  = 9;
  localparam int unsigned SymW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitW  = $clog2(ByteW);

  localparam logic [BitW-1:0] FirstBit = BitW'(ByteW - 1);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef enum logic [3:0] {
    STEP_IDLE  = 4'b0001,
    STEP_WALK  = 4'b0010,
    STEP_TEST  = 4'b0100,
    STEP_FLUSH = 4'b1000
  } step_e;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_DECODE = 2'd1,
    COND_DONE   = 2'd2
  } cond_e;

  typedef struct packed {
    logic  rdy;
    logic  walk;
    logic  test;
    logic  flush;
    cond_e cond;
    step_e go;
    step_e alt;
  } ctrl_t;

  typedef struct packed {
    logic decode;
    logic done;
    logic hold;
  } stat_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{rdy: 1'b0, walk: 1'b0, test: 1'b0, flush: 1'b0,
          cond: COND_ALWAYS, go: STEP_IDLE, alt: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.rdy  = 1'b1;
        w.cond = COND_DECODE;
        w.go   = STEP_WALK;
        w.alt  = STEP_IDLE;
      end
      STEP_WALK: begin
        w.walk = 1'b1;
        w.cond = COND_ALWAYS;
        w.go   = STEP_TEST;
        w.alt  = STEP_TEST;
      end
      STEP_TEST: begin
        w.test = 1'b1;
        w.cond = COND_DONE;
        w.go   = STEP_FLUSH;
        w.alt  = STEP_WALK;
      end
      STEP_FLUSH: begin
        w.flush = 1'b1;
        w.cond  = COND_ALWAYS;
        w.go    = STEP_IDLE;
        w.alt   = STEP_IDLE;
      end
      default: begin
        w.rdy  = 1'b1;
        w.cond = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/htbd_req_if.sv]
// Request channel: node writes and compressed bytes.
interface htbd_req_if;
  import htbd_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [IdxW-1:0] node_index;
  logic [IdxW-1:0] left_child;
  logic [IdxW-1:0] right_child;
  logic            is_leaf;
  logic [SymW-1:0] leaf_symbol;
  logic [ByteW-1:0] code_byte;

  modport source (
    output valid, req_type, node_index, left_child, right_child, is_leaf, leaf_symbol,
           code_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, node_index, left_child, right_child, is_leaf, leaf_symbol,
           code_byte,
    output ready
  );
endinterface

[hw/rtl/htbd_sym_if.sv]
// Result channel: decoded symbols with end-of-byte marker.
interface htbd_sym_if;
  import htbd_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;

  modport source (
    output valid, symbol, last,
    input  ready
  );

  modport sink (
    input  valid, symbol, last,
    output ready
  );
endinterface

[hw/rtl/htbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module htbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/htbd_useq.sv]
// Microcode sequencer: step register, control store lookup and next-step select.
module htbd_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  htbd_pkg::stat_t stat_i,
  output htbd_pkg::ctrl_t ctrl_o
);
  import htbd_pkg::*;

  step_e step_q, step_d;
  logic  take;

  assign ctrl_o = ucode(step_q);

  always_comb begin
    case (ctrl_o.cond)
      COND_ALWAYS: take = 1'b1;
      COND_DECODE: take = stat_i.decode;
      COND_DONE:   take = stat_i.done;
      default:     take = 1'b1;
    endcase
    if (stat_i.hold) begin
      step_d = step_q;
    end else if (take) begin
      step_d = ctrl_o.go;
    end else begin
      step_d = ctrl_o.alt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[hw/rtl/huffman_tree_bit_decoder_unit.sv]
// Huffman tree bit decoder: node table, tree walk datapath and output stage.
//
// Usage:
//   req_i carries two kinds of beat. A write beat (req_type 0) stores one tree
//   node at node_index if it is below MAX_NODES. A decode beat (req_type 1)
//   brings one compressed byte; its bits are walked from bit 7 down, and every
//   leaf reached yields one beat on rsp_o with the leaf symbol. The final
//   symbol of a byte carries last. Padding bits that stop on an inner node
//   emit nothing; the walk resumes there with the next byte.
//   cfg_we_i/cfg_wdata_i set the root index and restart the walk at the root.
//   Write the tree and the root only while no byte is in flight.
// Pacing:
//   A decode beat holds req_i.ready low until its byte has been walked and
//   flushed. The walk is paced by the single read port of the node table:
//   each bit needs one dependent node read, and each leaf one more read to
//   refetch the root.
// Reset and stall:
//   Reset sets the sequencer to STEP_IDLE and clears the root index and the
//   walk position to 0. The node table is not cleared. A stalled rsp_o holds
//   its beat; a leaf or flush that must emit waits for the output register.
module huffman_tree_bit_decoder_unit #(
  parameter int unsigned MAX_NODES   = htbd_pkg::MaxNodesDef,
  parameter int unsigned SYMBOL_BITS = htbd_pkg::SymbolBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [htbd_pkg::IdxW-1:0] cfg_wdata_i,
  htbd_req_if.sink                  req_i,
  htbd_sym_if.source                rsp_o
);
  import htbd_pkg::*;

  localparam int unsigned Depth    = (MAX_NODES < 2 ** IdxW) ? MAX_NODES : 2 ** IdxW;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned StoreSymW = (SYMBOL_BITS < SymW) ? SYMBOL_BITS : SymW;
  localparam int unsigned EntW     = 2 * IdxW + 1 + StoreSymW;

  function automatic logic in_range(logic [IdxW-1:0] idx);
    return 32'(idx) < MAX_NODES;
  endfunction

  ctrl_t ctrl;
  stat_t stat;

  logic [IdxW-1:0]      root_q;
  logic [IdxW-1:0]      pos_q, pos_d;
  logic [BitW-1:0]      bit_q, bit_d;
  logic [ByteW-1:0]     byte_q;
  logic [StoreSymW-1:0] pend_q, pend_d;
  logic                 pend_v_q, pend_v_d;
  logic                 out_v_q, out_v_d;
  logic [SymW-1:0]      out_sym_q, out_sym_d;
  logic                 out_last_q, out_last_d;
  logic                 rd_oob_q, rd_oob_d;

  logic                 acc, acc_wr, acc_dec;
  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      rd_idx;
  logic [EntW-1:0]      wdata, rdata;
  logic [IdxW-1:0]      nd_left, nd_right, child;
  logic                 nd_leaf;
  logic [StoreSymW-1:0] nd_sym;
  logic [BitW-1:0]      wbit;
  logic                 done, out_free, emit_need, blocked, hit_leaf, step_on;

  htbd_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign wdata = {StoreSymW'(req_i.leaf_symbol), req_i.is_leaf, req_i.right_child,
                  req_i.left_child};

  htbd_ram #(
    .WIDTH (EntW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.node_index[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign req_i.ready  = ctrl.rdy;
  assign rsp_o.valid  = out_v_q;
  assign rsp_o.symbol = out_sym_q;
  assign rsp_o.last   = out_last_q;

  always_comb begin
    acc     = req_i.valid & req_i.ready;
    acc_wr  = acc & (req_i.req_type == REQ_WRITE);
    acc_dec = acc & (req_i.req_type == REQ_DECODE);
    ram_we  = acc_wr & in_range(req_i.node_index);

    nd_left  = rd_oob_q ? '0 : rdata[IdxW-1:0];
    nd_right = rd_oob_q ? '0 : rdata[2*IdxW-1:IdxW];
    nd_leaf  = rd_oob_q ? 1'b0 : rdata[2*IdxW];
    nd_sym   = rd_oob_q ? '0 : rdata[EntW-1:2*IdxW+1];

    done      = (bit_q == '0);
    wbit      = ctrl.walk ? bit_q : bit_q - 1'b1;
    child     = byte_q[wbit] ? nd_right : nd_left;
    out_free  = !out_v_q || rsp_o.ready;
    hit_leaf  = ctrl.test & nd_leaf;
    emit_need = (hit_leaf | ctrl.flush) & pend_v_q;
    blocked   = emit_need & !out_free;
    step_on   = ctrl.test & !blocked & !done;

    stat.decode = acc_dec;
    stat.done   = done;
    stat.hold   = (ctrl.test & (blocked | (!nd_leaf & !done))) | (ctrl.flush & blocked);

    ram_re = 1'b0;
    rd_idx = pos_q;
    if (acc_dec) begin
      ram_re = 1'b1;
      rd_idx = pos_q;
    end else if (ctrl.walk) begin
      ram_re = 1'b1;
      rd_idx = child;
    end else if (step_on) begin
      ram_re = 1'b1;
      rd_idx = nd_leaf ? root_q : child;
    end
    rd_oob_d = ram_re ? !in_range(rd_idx) : rd_oob_q;

    pos_d = pos_q;
    if (cfg_we_i) begin
      pos_d = cfg_wdata_i;
    end else if (ctrl.walk) begin
      pos_d = child;
    end else if (ctrl.test & !blocked) begin
      if (nd_leaf) begin
        pos_d = root_q;
      end else if (!done) begin
        pos_d = child;
      end
    end

    bit_d = bit_q;
    if (acc_dec) begin
      bit_d = FirstBit;
    end else if (step_on) begin
      bit_d = bit_q - 1'b1;
    end

    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (hit_leaf & !blocked) begin
      pend_d   = nd_sym;
      pend_v_d = 1'b1;
    end else if (ctrl.flush & !blocked) begin
      pend_v_d = 1'b0;
    end

    out_v_d    = out_v_q & !rsp_o.ready;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    if (emit_need & out_free) begin
      out_v_d    = 1'b1;
      out_sym_d  = SymW'(pend_q);
      out_last_d = ctrl.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q   <= '0;
      pos_q    <= '0;
      bit_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      rd_oob_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      bit_q    <= bit_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      rd_oob_q <= rd_oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_dec) begin
      byte_q <= req_i.code_byte;
    end
    pend_q     <= pend_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  a_dec_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_dec |=> !req_i.ready)
    else $error("input taken while a byte is being walked");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rdy |-> !pend_v_q)
    else $error("symbol left pending after end of byte");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(ctrl.test || ctrl.flush))
    else $error("output beat raised outside leaf test or flush");

endmodule
